// ===== hw/rtl/lls_pkg.sv =====
`default_nettype none

package lls_pkg;

  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 4;
  localparam int DELTA_W  = 16;
  localparam int LIMIT_W  = 16;
  localparam int STATUS_W = 2;
  localparam int PCT_W    = 7;
  localparam int DIV_STEPS = PCT_W;

  localparam logic [PCT_W-1:0] PCT_INIT = 7'd100;

  localparam logic [CMD_W-1:0] CMD_CHOOSE     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ACTIVATE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DEACTIVATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_LIMIT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ADD_LOAD   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SET_AUTHED = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE_ELIGIBLE = 2'd2;

  typedef struct packed {
    logic cap;
    logic scan_init;
    logic rd_scan;
    logic wr_cmd;
    logic res_cmd;
    logic div_init;
    logic div_step;
    logic cmp;
    logic idx_inc;
    logic res_scan;
  } ctl_t;

  typedef struct packed {
    logic req_choose;
    logic elig;
    logic last;
    logic div_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lls_dpath.sv =====
`default_nettype none

module lls_dpath
  import lls_pkg::*;
#(
  parameter int NUM_SLOTS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ctl_t                       ctl,
  output sts_t                            sts,
  input  wire logic [CMD_W-1:0]           cmd,
  input  wire logic [SLOT_W-1:0]          slot,
  input  wire logic signed [DELTA_W-1:0]  load_delta,
  input  wire logic [LIMIT_W-1:0]         limit_value,
  input  wire logic                       authed_value,
  output logic [STATUS_W-1:0]             status,
  output logic [SLOT_W-1:0]               chosen_slot,
  output logic [PCT_W-1:0]                chosen_percent
);

  localparam int SI = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = COUNT_BITS;
  localparam int NW = CW + PCT_W;
  localparam int SW = ((CW > DELTA_W) ? CW : DELTA_W) + 2;
  localparam logic [CW-1:0] CNT_MAX = '1;

  // request
  logic [CMD_W-1:0]          cmd_r;
  logic [SLOT_W-1:0]         slot_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic [LIMIT_W-1:0]        limit_r;
  logic                      auth_r;

  logic [NUM_SLOTS-1:0] act_v, auth_v, vld_v;
  logic [CW-1:0] load_mem  [NUM_SLOTS];
  logic [CW-1:0] limit_mem [NUM_SLOTS];

  logic [SI-1:0] ra, wa;
  logic [CW-1:0] rd_load, rd_limit, eff_load, eff_lim;
  logic          rd_act, rd_auth, rd_vld;
  logic          slot_ok, wr_en;

  logic          n_act, n_auth;
  logic [CW-1:0] n_load, n_lim;
  logic signed [SW-1:0] sum_s;

  logic [SI-1:0]    idx;
  logic [PCT_W-1:0] best;
  logic [SI-1:0]    chosen;
  logic             found;

  logic [NW-1:0] num, trial, mul100;
  logic [CW-1:0] den;
  logic [PCT_W-1:0] q;
  logic [2:0]    step;
  logic          ge, take;

  logic             fin_found;
  logic [PCT_W-1:0] fin_best;
  logic [SI-1:0]    fin_chosen;

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      cmd_r   <= cmd;
      slot_r  <= slot;
      delta_r <= load_delta;
      limit_r <= limit_value;
      auth_r  <= authed_value;
    end
  end

  assign slot_ok = (32'(slot_r) < NUM_SLOTS);
  assign wa      = SI'(slot_r);
  assign ra      = ctl.rd_scan ? idx : wa;
  assign wr_en   = ctl.wr_cmd && slot_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      load_mem[wa]  <= n_load;
      limit_mem[wa] <= n_lim;
    end
    rd_load  <= load_mem[ra];
    rd_limit <= limit_mem[ra];
    rd_act   <= act_v[ra];
    rd_auth  <= auth_v[ra];
    rd_vld   <= vld_v[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_v  <= '0;
      auth_v <= '0;
      vld_v  <= '0;
    end else if (wr_en) begin
      act_v[wa]  <= n_act;
      auth_v[wa] <= n_auth;
      vld_v[wa]  <= 1'b1;
    end
  end

  // entries never written read as zero
  assign eff_load = rd_vld ? rd_load : '0;
  assign eff_lim  = rd_vld ? rd_limit : '0;

  assign sum_s = $signed(SW'(eff_load)) + SW'(delta_r);

  always_comb begin
    n_act  = rd_act;
    n_auth = rd_auth;
    n_load = eff_load;
    n_lim  = eff_lim;
    unique case (cmd_r)
      CMD_ACTIVATE: begin
        n_act  = 1'b1;
        n_auth = 1'b1;
        n_load = '0;
        n_lim  = '0;
      end
      CMD_DEACTIVATE: begin
        // an inactive slot keeps its entries
        if (rd_act) begin
          n_act  = 1'b0;
          n_auth = 1'b0;
          n_load = '0;
          n_lim  = '0;
        end
      end
      CMD_SET_LIMIT: n_lim = CW'(limit_r);
      CMD_ADD_LOAD: begin
        if (sum_s < 0) begin
          n_load = '0;
        end else if (sum_s > $signed(SW'(CNT_MAX))) begin
          n_load = CNT_MAX;
        end else begin
          n_load = CW'(sum_s);
        end
      end
      CMD_SET_AUTHED: n_auth = auth_r;
      default: ;
    endcase
  end

  // 100*load as shifts and adds
  assign mul100 = NW'({eff_load, 6'b0}) + NW'({eff_load, 5'b0}) + NW'({eff_load, 2'b0});
  assign trial  = NW'(den) << step;
  assign ge     = (num >= trial);

  always_ff @(posedge clk) begin
    if (ctl.div_init) begin
      num  <= mul100;
      den  <= eff_lim;
      q    <= '0;
      step <= 3'(DIV_STEPS - 1);
    end else if (ctl.div_step) begin
      if (ge) begin
        num     <= num - trial;
        q[step] <= 1'b1;
      end
      step <= step - 3'd1;
    end
  end

  assign take       = ctl.cmp && (q < best);
  assign fin_found  = found | take;
  assign fin_best   = take ? q : best;
  assign fin_chosen = take ? idx : chosen;

  always_ff @(posedge clk) begin
    if (ctl.scan_init) begin
      idx   <= '0;
      best  <= PCT_INIT;
      found <= 1'b0;
    end else begin
      if (take) begin
        best   <= q;
        chosen <= idx;
        found  <= 1'b1;
      end
      if (ctl.idx_inc) begin
        idx <= idx + SI'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_cmd) begin
      status         <= (cmd_r == CMD_DEACTIVATE && slot_ok && !rd_act) ? ST_NOT_ACTIVE
                                                                        : ST_OK;
      chosen_slot    <= '0;
      chosen_percent <= '0;
    end else if (ctl.res_scan) begin
      if (fin_found) begin
        status         <= ST_OK;
        chosen_slot    <= SLOT_W'(fin_chosen);
        chosen_percent <= fin_best;
      end else begin
        status         <= ST_NONE_ELIGIBLE;
        chosen_slot    <= '0;
        chosen_percent <= '0;
      end
    end
  end

  assign sts.req_choose = (cmd == CMD_CHOOSE);
  assign sts.elig       = rd_act && rd_auth && (eff_lim != '0) && (eff_load < eff_lim);
  assign sts.last       = (idx == SI'(NUM_SLOTS - 1));
  assign sts.div_last   = (step == 3'd0);

endmodule

`default_nettype wire

// ===== hw/rtl/lls_ctrl.sv =====
`default_nettype none

module lls_ctrl
  import lls_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire sts_t sts,
  output ctl_t      ctl,
  output logic      busy,
  output logic      done
);

  typedef enum logic [2:0] {
    IDLE, CMD_RD, CMD_WR, SC_RD, SC_CHK, SC_DIV, SC_CMP
  } state_t;

  state_t state;

  always_comb begin
    ctl = '0;
    unique case (state)
      IDLE: begin
        ctl.cap       = start;
        ctl.scan_init = start && sts.req_choose;
      end
      CMD_RD: ctl.rd_scan = 1'b0;
      CMD_WR: begin
        ctl.wr_cmd  = 1'b1;
        ctl.res_cmd = 1'b1;
      end
      SC_RD: ctl.rd_scan = 1'b1;
      SC_CHK: begin
        ctl.div_init = sts.elig;
        ctl.res_scan = !sts.elig && sts.last;
        ctl.idx_inc  = !sts.elig && !sts.last;
      end
      SC_DIV: ctl.div_step = 1'b1;
      SC_CMP: begin
        ctl.cmp      = 1'b1;
        ctl.res_scan = sts.last;
        ctl.idx_inc  = !sts.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (start) begin
            busy  <= 1'b1;
            state <= sts.req_choose ? SC_RD : CMD_RD;
          end
        end
        CMD_RD: state <= CMD_WR;
        CMD_WR: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= IDLE;
        end
        SC_RD: state <= SC_CHK;
        SC_CHK: begin
          if (sts.elig) begin
            state <= SC_DIV;
          end else if (sts.last) begin
            done  <= 1'b1;
            busy  <= 1'b0;
            state <= IDLE;
          end else begin
            state <= SC_RD;
          end
        end
        SC_DIV: begin
          if (sts.div_last) begin
            state <= SC_CMP;
          end
        end
        SC_CMP: begin
          if (sts.last) begin
            done  <= 1'b1;
            busy  <= 1'b0;
            state <= IDLE;
          end else begin
            state <= SC_RD;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but not busy");
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    (state == SC_DIV) |-> busy)
    else $error("divider running while idle");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == CMD_WR || $past(state) == SC_CHK || $past(state) == SC_CMP))
    else $error("result strobe from wrong state");

endmodule

`default_nettype wire

// ===== hw/rtl/least_loaded_server_select_core.sv =====
`default_nettype none

// channel  | handshake          | payload
// request  | start in, busy out | cmd, slot, load_delta, limit_value, authed_value
// result   | done out (strobe)  | status, chosen_slot, chosen_percent
//
// Request taken when start is high and busy low; one result per request,
// shown for the single cycle that done is high.
// Commands other than choose: done rises after a read state and a write-back state (CMD_RD, CMD_WR).
// Choose: each slot is read (SC_RD) and checked (SC_CHK); an eligible slot then
// runs the restoring divider shared by all slots (SC_DIV) and is compared (SC_CMP);
// done rises when the last slot is finished.
// rst clears all slot flags at once; no clearing pass.
// The receiver cannot stall; busy drops as done rises, so the next request
// can be taken in the strobe cycle.

module least_loaded_server_select_core
  import lls_pkg::*;
#(
  parameter int NUM_SLOTS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [CMD_W-1:0]          cmd,
  input  wire logic [SLOT_W-1:0]         slot,
  input  wire logic signed [DELTA_W-1:0] load_delta,
  input  wire logic [LIMIT_W-1:0]        limit_value,
  input  wire logic                      authed_value,
  output logic                           done,
  output logic [STATUS_W-1:0]            status,
  output logic [SLOT_W-1:0]              chosen_slot,
  output logic [PCT_W-1:0]               chosen_percent
);

  ctl_t ctl;
  sts_t sts;

  lls_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  lls_dpath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .cmd            (cmd),
    .slot           (slot),
    .load_delta     (load_delta),
    .limit_value    (limit_value),
    .authed_value   (authed_value),
    .status         (status),
    .chosen_slot    (chosen_slot),
    .chosen_percent (chosen_percent)
  );

endmodule

`default_nettype wire
